FILE: hdl/dls_pkg.sv
package dls_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int PIX_W  = COORD_BITS + 1;
    localparam int INT_W  = COORD_BITS + 2;
    localparam int POS_W  = INT_W + FRAC_BITS;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int INC_W  = QUO_W + 1;
    localparam int IDX_W  = COORD_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 2);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] DOT_PERIOD = 3'd5;
    localparam logic [3:0] DASH_ON    = 4'd5;
    localparam logic [3:0] DASH_END   = 4'd10;

    typedef enum logic [0:0] {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STYLE_SOLID  = 2'd0,
        STYLE_DOTTED = 2'd1,
        STYLE_DASHED = 2'd2
    } style_t;

    typedef enum logic [2:0] {
        ST_PLOT   = 3'd0,
        ST_SKIP   = 3'd1,
        ST_START  = 3'd2,
        ST_REJECT = 3'd3,
        ST_IDLE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_STEP   = 2'd0,
        CMD_START  = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                     kind;
        logic signed [COORD_BITS-1:0]  x1;
        logic signed [COORD_BITS-1:0]  y1;
        logic                          neg_x;
        logic                          neg_y;
        logic [MAG_W-1:0]              mag_x;
        logic [MAG_W-1:0]              mag_y;
        logic [MAG_W-1:0]              len;
        logic [1:0]                    style;
    } cmd_t;

endpackage

FILE: hdl/dls_front.sv
module dls_front (
    input  logic                                   req_type,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  start_x,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  start_y,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  end_x,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  end_y,
    input  logic [1:0]                             line_style,
    output dls_pkg::cmd_t                          cmd
);

    logic signed [dls_pkg::DIFF_W-1:0] ddx;
    logic signed [dls_pkg::DIFF_W-1:0] ddy;
    logic [dls_pkg::DIFF_W-1:0]        abs_x;
    logic [dls_pkg::DIFF_W-1:0]        abs_y;
    logic [dls_pkg::MAG_W-1:0]         mag_x;
    logic [dls_pkg::MAG_W-1:0]         mag_y;
    logic [dls_pkg::MAG_W-1:0]         len;

    assign ddx   = {end_x[dls_pkg::COORD_BITS-1], end_x}
                 - {start_x[dls_pkg::COORD_BITS-1], start_x};
    assign ddy   = {end_y[dls_pkg::COORD_BITS-1], end_y}
                 - {start_y[dls_pkg::COORD_BITS-1], start_y};
    assign abs_x = ddx[dls_pkg::DIFF_W-1] ? -ddx : ddx;
    assign abs_y = ddy[dls_pkg::DIFF_W-1] ? -ddy : ddy;
    assign mag_x = abs_x[dls_pkg::MAG_W-1:0];
    assign mag_y = abs_y[dls_pkg::MAG_W-1:0];
    assign len   = (mag_x >= mag_y) ? mag_x : mag_y;

    always_comb
    begin
        cmd.x1    = start_x;
        cmd.y1    = start_y;
        cmd.neg_x = ddx[dls_pkg::DIFF_W-1];
        cmd.neg_y = ddy[dls_pkg::DIFF_W-1];
        cmd.mag_x = mag_x;
        cmd.mag_y = mag_y;
        cmd.len   = len;
        cmd.style = line_style;
        if (req_type == dls_pkg::REQ_STEP)
        begin
            cmd.kind = dls_pkg::CMD_STEP;
        end
        else if (len == '0)
        begin
            cmd.kind = dls_pkg::CMD_REJECT;
        end
        else
        begin
            cmd.kind = dls_pkg::CMD_START;
        end
    end

endmodule

FILE: hdl/dls_queue.sv
module dls_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_stall,
    input  dls_pkg::cmd_t  push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output dls_pkg::cmd_t  pop_cmd
);

    dls_pkg::cmd_t                entry_reg [dls_pkg::QDEPTH];
    logic [dls_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [dls_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [dls_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_stall = (count_reg == dls_pkg::QCNT_W'(dls_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == dls_pkg::QPTR_W'(dls_pkg::QDEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == dls_pkg::QPTR_W'(dls_pkg::QDEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/dls_back.sv
module dls_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_pop,
    input  dls_pkg::cmd_t                         cmd,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [2:0]                            status,
    output logic signed [dls_pkg::PIX_W-1:0]      pixel_x,
    output logic signed [dls_pkg::PIX_W-1:0]      pixel_y,
    output logic                                  last_step
);

    typedef enum logic [0:0] {
        S_RUN = 1'b0,
        S_DIV = 1'b1
    } state_t;

    function automatic logic signed [dls_pkg::PIX_W-1:0] trunc_pix(
        input logic signed [dls_pkg::POS_W-1:0] p
    );
        logic signed [dls_pkg::INT_W-1:0] fl;
        fl = p[dls_pkg::POS_W-1:dls_pkg::FRAC_BITS];
        if (p[dls_pkg::POS_W-1] && (p[dls_pkg::FRAC_BITS-1:0] != '0))
        begin
            fl = fl + 1'b1;
        end
        return fl[dls_pkg::PIX_W-1:0];
    endfunction

    function automatic logic signed [dls_pkg::POS_W-1:0] start_pos(
        input logic signed [dls_pkg::COORD_BITS-1:0] c,
        input logic                                  neg
    );
        logic [dls_pkg::POS_W-1:0] base;
        base = {{(dls_pkg::INT_W - dls_pkg::COORD_BITS){c[dls_pkg::COORD_BITS-1]}},
                c, dls_pkg::FRAC_BITS'(0)};
        return neg ? (base - dls_pkg::HALF) : (base + dls_pkg::HALF);
    endfunction

    state_t                                 state_reg;
    logic                                   out_valid_reg;
    logic [2:0]                             status_reg;
    logic signed [dls_pkg::PIX_W-1:0]       pixel_x_reg;
    logic signed [dls_pkg::PIX_W-1:0]       pixel_y_reg;
    logic                                   last_reg;

    logic signed [dls_pkg::POS_W-1:0]       pos_x_reg;
    logic signed [dls_pkg::POS_W-1:0]       pos_y_reg;
    logic signed [dls_pkg::INC_W-1:0]       inc_x_reg;
    logic signed [dls_pkg::INC_W-1:0]       inc_y_reg;
    logic [dls_pkg::IDX_W-1:0]              step_idx_reg;
    logic [dls_pkg::MAG_W-1:0]              len_reg;
    logic [2:0]                             mod5_reg;
    logic [3:0]                             dash_reg;
    logic [1:0]                             style_reg;
    logic                                   active_reg;

    logic [dls_pkg::MAG_W-1:0]              rem_x_reg;
    logic [dls_pkg::MAG_W-1:0]              rem_y_reg;
    logic [dls_pkg::QUO_W-1:0]              quo_x_reg;
    logic [dls_pkg::QUO_W-1:0]              quo_y_reg;
    logic [dls_pkg::CNT_W-1:0]              div_cnt_reg;
    logic                                   neg_x_reg;
    logic                                   neg_y_reg;
    logic signed [dls_pkg::COORD_BITS-1:0]  x1_reg;
    logic signed [dls_pkg::COORD_BITS-1:0]  y1_reg;

    logic                                   out_free;
    logic                                   beat_load;
    logic                                   div_first;
    logic                                   div_done;
    logic [dls_pkg::MAG_W:0]                trial_x;
    logic [dls_pkg::MAG_W:0]                trial_y;
    logic [dls_pkg::MAG_W:0]                diff_x;
    logic [dls_pkg::MAG_W:0]                diff_y;
    logic                                   ge_x;
    logic                                   ge_y;
    logic signed [dls_pkg::POS_W-1:0]       pos_x_sum;
    logic signed [dls_pkg::POS_W-1:0]       pos_y_sum;
    logic                                   plot;
    logic                                   last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd_pop   = (state_reg == S_RUN) && cmd_valid && out_free;
    assign div_first = (div_cnt_reg == '0);
    assign div_done  = (div_cnt_reg == dls_pkg::CNT_W'(dls_pkg::FRAC_BITS + 1));
    assign beat_load = (cmd_pop && ((cmd.kind == dls_pkg::CMD_STEP)
                                    || (cmd.kind == dls_pkg::CMD_REJECT)))
                     || ((state_reg == S_DIV) && div_done && out_free);

    // restoring division, one quotient bit per cycle on both axes
    assign trial_x = div_first ? {1'b0, rem_x_reg} : {rem_x_reg, 1'b0};
    assign trial_y = div_first ? {1'b0, rem_y_reg} : {rem_y_reg, 1'b0};
    assign diff_x  = trial_x - {1'b0, len_reg};
    assign diff_y  = trial_y - {1'b0, len_reg};
    assign ge_x    = trial_x >= {1'b0, len_reg};
    assign ge_y    = trial_y >= {1'b0, len_reg};

    assign pos_x_sum = pos_x_reg
        + {{(dls_pkg::POS_W - dls_pkg::INC_W){inc_x_reg[dls_pkg::INC_W-1]}}, inc_x_reg};
    assign pos_y_sum = pos_y_reg
        + {{(dls_pkg::POS_W - dls_pkg::INC_W){inc_y_reg[dls_pkg::INC_W-1]}}, inc_y_reg};
    assign last      = step_idx_reg >= {1'b0, len_reg};

    always_comb
    begin
        case (style_reg)
            dls_pkg::STYLE_DOTTED: plot = (mod5_reg == '0);
            dls_pkg::STYLE_DASHED: plot = (dash_reg < dls_pkg::DASH_ON);
            default:               plot = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            pixel_x_reg   <= '0;
            pixel_y_reg   <= '0;
            last_reg      <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            inc_x_reg     <= '0;
            inc_y_reg     <= '0;
            step_idx_reg  <= '0;
            len_reg       <= '0;
            mod5_reg      <= '0;
            dash_reg      <= '0;
            style_reg     <= '0;
            active_reg    <= 1'b0;
            rem_x_reg     <= '0;
            rem_y_reg     <= '0;
            quo_x_reg     <= '0;
            quo_y_reg     <= '0;
            div_cnt_reg   <= '0;
            neg_x_reg     <= 1'b0;
            neg_y_reg     <= 1'b0;
            x1_reg        <= '0;
            y1_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !beat_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_RUN:
                begin
                    if (cmd_pop)
                    begin
                        case (cmd.kind)
                            dls_pkg::CMD_STEP:
                            begin
                                out_valid_reg <= 1'b1;
                                if (!active_reg)
                                begin
                                    status_reg  <= dls_pkg::ST_IDLE;
                                    pixel_x_reg <= '0;
                                    pixel_y_reg <= '0;
                                    last_reg    <= 1'b0;
                                end
                                else
                                begin
                                    pos_x_reg    <= pos_x_sum;
                                    pos_y_reg    <= pos_y_sum;
                                    status_reg   <= plot ? dls_pkg::ST_PLOT : dls_pkg::ST_SKIP;
                                    pixel_x_reg  <= trunc_pix(pos_x_sum);
                                    pixel_y_reg  <= trunc_pix(pos_y_sum);
                                    last_reg     <= last;
                                    step_idx_reg <= step_idx_reg + 1'b1;
                                    mod5_reg     <= (mod5_reg == dls_pkg::DOT_PERIOD - 3'd1)
                                                  ? '0 : mod5_reg + 1'b1;
                                    if (style_reg == dls_pkg::STYLE_DASHED)
                                    begin
                                        dash_reg <= (dash_reg >= dls_pkg::DASH_END)
                                                  ? '0 : dash_reg + 1'b1;
                                    end
                                    if (last)
                                    begin
                                        active_reg <= 1'b0;
                                    end
                                end
                            end
                            dls_pkg::CMD_REJECT:
                            begin
                                active_reg    <= 1'b0;
                                out_valid_reg <= 1'b1;
                                status_reg    <= dls_pkg::ST_REJECT;
                                pixel_x_reg   <= '0;
                                pixel_y_reg   <= '0;
                                last_reg      <= 1'b0;
                            end
                            dls_pkg::CMD_START:
                            begin
                                active_reg  <= 1'b0;
                                rem_x_reg   <= cmd.mag_x;
                                rem_y_reg   <= cmd.mag_y;
                                len_reg     <= cmd.len;
                                quo_x_reg   <= '0;
                                quo_y_reg   <= '0;
                                div_cnt_reg <= '0;
                                neg_x_reg   <= cmd.neg_x;
                                neg_y_reg   <= cmd.neg_y;
                                x1_reg      <= cmd.x1;
                                y1_reg      <= cmd.y1;
                                style_reg   <= cmd.style;
                                pos_x_reg   <= start_pos(cmd.x1, cmd.neg_x);
                                pos_y_reg   <= start_pos(cmd.y1, cmd.neg_y);
                                state_reg   <= S_DIV;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (!div_done)
                    begin
                        rem_x_reg   <= ge_x ? diff_x[dls_pkg::MAG_W-1:0]
                                            : trial_x[dls_pkg::MAG_W-1:0];
                        rem_y_reg   <= ge_y ? diff_y[dls_pkg::MAG_W-1:0]
                                            : trial_y[dls_pkg::MAG_W-1:0];
                        quo_x_reg   <= {quo_x_reg[dls_pkg::QUO_W-2:0], ge_x};
                        quo_y_reg   <= {quo_y_reg[dls_pkg::QUO_W-2:0], ge_y};
                        div_cnt_reg <= div_cnt_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        inc_x_reg     <= neg_x_reg ? (dls_pkg::INC_W'(0) - {1'b0, quo_x_reg})
                                                   : {1'b0, quo_x_reg};
                        inc_y_reg     <= neg_y_reg ? (dls_pkg::INC_W'(0) - {1'b0, quo_y_reg})
                                                   : {1'b0, quo_y_reg};
                        step_idx_reg  <= '0;
                        mod5_reg      <= '0;
                        dash_reg      <= '0;
                        active_reg    <= 1'b1;
                        out_valid_reg <= 1'b1;
                        status_reg    <= dls_pkg::ST_START;
                        pixel_x_reg   <= {x1_reg[dls_pkg::COORD_BITS-1], x1_reg};
                        pixel_y_reg   <= {y1_reg[dls_pkg::COORD_BITS-1], y1_reg};
                        last_reg      <= 1'b0;
                        state_reg     <= S_RUN;
                    end
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last_step = last_reg;

    a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !cmd_pop)
        else $error("command taken during division");

    a_index_within_line: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_idx_reg <= {1'b0, len_reg}))
        else $error("step index beyond line length");

    a_dash_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dash_reg <= dls_pkg::DASH_END) && (mod5_reg < dls_pkg::DOT_PERIOD))
        else $error("pattern counter out of range");

    a_step_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && (cmd.kind != dls_pkg::CMD_START)) |=> out_valid_reg)
        else $error("step or reject gave no result beat");

endmodule

FILE: hdl/dda_styled_line_stepper.sv
// channel  handshake            payload
// in       in_valid / in_stall  req_type, start_x, start_y, end_x, end_y, line_style
// out      out_valid / out_stall status, pixel_x, pixel_y, last_step
//
// steps go straight to the output register, one per cycle while out_stall is low
// a start beat holds the stepper for load, a two-axis restoring divider run (one
// quotient bit per step on both axes in parallel) and finish
// a two-beat command queue sits between the input and the stepper
// rst_n clears the queue, the stepper state and the output register at once
// out_stall holds the output register and the stepper; the queue keeps taking beats until full
module dda_styled_line_stepper (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   req_type,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  start_x,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  start_y,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  end_x,
    input  logic signed [dls_pkg::COORD_BITS-1:0]  end_y,
    input  logic [1:0]                             line_style,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [2:0]                             status,
    output logic signed [dls_pkg::PIX_W-1:0]       pixel_x,
    output logic signed [dls_pkg::PIX_W-1:0]       pixel_y,
    output logic                                   last_step
);

    dls_pkg::cmd_t front_cmd;
    dls_pkg::cmd_t head_cmd;
    logic          head_valid;
    logic          head_pop;

    dls_front u_front (
        .req_type   (req_type),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_style (line_style),
        .cmd        (front_cmd)
    );

    dls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_cmd   (front_cmd),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_cmd    (head_cmd)
    );

    dls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (head_valid),
        .cmd_pop    (head_pop),
        .cmd        (head_cmd),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_step  (last_step)
    );

endmodule
